// ===== hdl/crc16rfc_pkg.sv =====
package crc16rfc_pkg;

  // CRC-16 generator polynomial
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Shortest frame that holds a count byte and two CRC bytes
  localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

  // One frame verdict
  typedef struct packed {
    logic       frame_ok;
    logic       length_ok;
    logic       crc_ok;
    logic [7:0] status_byte;
  } res_t;

  // Advance the CRC by one byte, data bits LSB first, register MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      fb = data[b] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc16_response_frame_checker.sv =====
// Response frame checker: takes one frame byte per transaction, with
// frame_start marking the count byte, and gives one verdict transaction on
// the last byte of each frame (length match, CRC-16/0x8005 match, overall
// result and the frame's second byte). The CRC update is an unrolled
// eight-bit step between the input and the frame state registers, so a
// byte can be accepted in any cycle with in_stall low. Results wait in an
// output register backed by one skid entry; in_stall rises only while both
// hold a verdict that the receiver has not taken. A frame whose expected
// length is below three fails on its first byte. Bytes outside a frame are
// dropped without a result.
module crc16_response_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  input  logic [7:0] in_expected_len,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_ok,
  output logic       out_length_ok,
  output logic       out_crc_ok,
  output logic [7:0] out_status_byte
);
  import crc16rfc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  flen_r, flen_nxt;
  logic        cnt_match_r, cnt_match_nxt;
  logic        lo_match_r, lo_match_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        in_frame_r, in_frame_nxt;

  res_t        out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r;
  logic        res_valid;
  logic        in_acc, out_pop;

  logic [15:0] crc_cur;
  logic [7:0]  idx_cur, flen_cur, flen_m2, status_cur;
  logic        cnt_match_cur, lo_match_cur, crc_good;

  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid_r && !out_stall;

  // Frame state update for one accepted byte
  always_comb begin
    crc_nxt       = crc_r;
    idx_nxt       = idx_r;
    flen_nxt      = flen_r;
    cnt_match_nxt = cnt_match_r;
    lo_match_nxt  = lo_match_r;
    status_nxt    = status_r;
    in_frame_nxt  = in_frame_r;
    res_valid     = 1'b0;
    res           = '0;

    // restart values on frame_start, else the held frame state
    crc_cur       = in_frame_start ? 16'd0 : crc_r;
    idx_cur       = in_frame_start ? 8'd0 : idx_r;
    flen_cur      = in_frame_start ? in_expected_len : flen_r;
    cnt_match_cur = in_frame_start ? 1'b0 : cnt_match_r;
    lo_match_cur  = in_frame_start ? 1'b0 : lo_match_r;
    status_cur    = in_frame_start ? 8'd0 : status_r;
    flen_m2       = flen_cur - 8'd2;
    crc_good      = 1'b0;

    if (in_acc) begin
      if (in_frame_start && (in_expected_len < MIN_FRAME_LEN)) begin
        // fail a too-short frame at once
        crc_nxt       = 16'd0;
        idx_nxt       = 8'd0;
        flen_nxt      = in_expected_len;
        cnt_match_nxt = 1'b0;
        lo_match_nxt  = 1'b0;
        status_nxt    = 8'd0;
        in_frame_nxt  = 1'b0;
        res_valid     = 1'b1;
        res.length_ok = (in_rx_byte == in_expected_len);
      end else if (in_frame_start || in_frame_r) begin
        flen_nxt     = flen_cur;
        in_frame_nxt = 1'b1;
        if (idx_cur == 8'd0) begin
          cnt_match_cur = (in_rx_byte == flen_cur);
        end
        if (idx_cur == 8'd1) begin
          status_cur = in_rx_byte;
        end
        cnt_match_nxt = cnt_match_cur;
        status_nxt    = status_cur;
        crc_nxt       = crc_cur;
        lo_match_nxt  = lo_match_cur;
        idx_nxt       = idx_cur + 8'd1;
        if (idx_cur < flen_m2) begin
          crc_nxt = crc_feed(crc_cur, in_rx_byte);
        end else if (idx_cur == flen_m2) begin
          lo_match_nxt = (in_rx_byte == crc_cur[7:0]);
        end else begin
          // last byte: close the frame and report
          crc_good        = lo_match_cur && (in_rx_byte == crc_cur[15:8]);
          res.frame_ok    = cnt_match_cur && crc_good;
          res.length_ok   = cnt_match_cur;
          res.crc_ok      = crc_good;
          res.status_byte = status_cur;
          res_valid       = 1'b1;
          in_frame_nxt    = 1'b0;
          idx_nxt         = 8'd0;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 16'd0;
      idx_r       <= 8'd0;
      flen_r      <= 8'd0;
      cnt_match_r <= 1'b0;
      lo_match_r  <= 1'b0;
      status_r    <= 8'd0;
      in_frame_r  <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      idx_r       <= idx_nxt;
      flen_r      <= flen_nxt;
      cnt_match_r <= cnt_match_nxt;
      lo_match_r  <= lo_match_nxt;
      status_r    <= status_nxt;
      in_frame_r  <= in_frame_nxt;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Move payloads: skid drains first, then new verdicts
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_r.frame_ok;
  assign out_length_ok   = out_r.length_ok;
  assign out_crc_ok      = out_r.crc_ok;
  assign out_status_byte = out_r.status_byte;

endmodule

// ===== hdl/crc16rfc_checker.sv =====
module crc16rfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       in_frame_start,
  input logic [7:0] in_expected_len,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_frame_ok,
  input logic       out_length_ok,
  input logic       out_crc_ok,
  input logic [7:0] out_status_byte
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_ok) &&
      $stable(out_length_ok) && $stable(out_crc_ok) && $stable(out_status_byte))
    else $error("stalled result changed or dropped");

  // Overall verdict is the AND of both checks
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_ok == (out_length_ok && out_crc_ok)))
    else $error("frame_ok disagrees with length_ok and crc_ok");

  // Input stalls only while a result already waits
  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A too-short frame fails on its first byte
  a_short_fail: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_frame_start && (in_expected_len < 8'd3) &&
      !(out_valid && out_stall)
    |=> out_valid && !out_frame_ok && !out_crc_ok && (out_status_byte == 8'd0))
    else $error("short frame not failed at once");

endmodule

bind crc16_response_frame_checker crc16rfc_checker u_crc16rfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_rx_byte      (in_rx_byte),
  .in_frame_start  (in_frame_start),
  .in_expected_len (in_expected_len),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_frame_ok    (out_frame_ok),
  .out_length_ok   (out_length_ok),
  .out_crc_ok      (out_crc_ok),
  .out_status_byte (out_status_byte)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import crc16rfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 10;

  // One byte transaction as offered on the input channel
  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    logic [7:0] len;
  } rx_item_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte      = 8'h00;
  logic       in_frame_start  = 1'b0;
  logic [7:0] in_expected_len = 8'h00;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic       out_frame_ok;
  logic       out_length_ok;
  logic       out_crc_ok;
  logic [7:0] out_status_byte;

  always #5 clk = ~clk;

  crc16_response_frame_checker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_frame_start  (in_frame_start),
    .in_expected_len (in_expected_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ok    (out_frame_ok),
    .out_length_ok   (out_length_ok),
    .out_crc_ok      (out_crc_ok),
    .out_status_byte (out_status_byte)
  );

  rx_item_t rx_queue[$];
  res_t     verdict_q[$];
  rx_item_t cur_byte;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  int pushed        = 0;
  int bytes_taken   = 0;
  int verdicts_seen = 0;
  int good_frames   = 0;
  int dropped_bytes = 0;
  int fail_count    = 0;

  // Frame tracking state of the predictor
  logic [15:0] crc_run      = 16'h0000;
  logic [7:0]  byte_pos     = 8'h00;
  logic [7:0]  len_goal     = 8'h00;
  logic        count_good   = 1'b0;
  logic        crc_lo_good  = 1'b0;
  logic [7:0]  status_hold  = 8'h00;
  logic        frame_open   = 1'b0;

  // Advance the checksum by one byte, data LSB first into an MSB-first register
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = data[i] ^ acc[15];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  // Update the frame state for one accepted byte and queue any verdict it yields
  task automatic predict_byte(input rx_item_t b);
    logic [7:0] lo_pos;
    logic       crc_good;
    res_t       v;
    if (b.start) begin
      crc_run     = 16'h0000;
      byte_pos    = 8'h00;
      len_goal    = b.len;
      count_good  = 1'b0;
      crc_lo_good = 1'b0;
      status_hold = 8'h00;
      frame_open  = 1'b1;
      // too short to hold a count and a checksum: fail on the spot
      if (b.len < MIN_FRAME_LEN) begin
        frame_open    = 1'b0;
        v.frame_ok    = 1'b0;
        v.length_ok   = (b.rx == b.len);
        v.crc_ok      = 1'b0;
        v.status_byte = 8'h00;
        verdict_q.push_back(v);
        return;
      end
    end else if (!frame_open) begin
      dropped_bytes++;
      return;
    end
    if (byte_pos == 8'd0) count_good = (b.rx == len_goal);
    if (byte_pos == 8'd1) status_hold = b.rx;
    lo_pos = len_goal - 8'd2;
    if (byte_pos < lo_pos) begin
      crc_run = crc16_step(crc_run, b.rx);
    end else if (byte_pos == lo_pos) begin
      crc_lo_good = (b.rx == crc_run[7:0]);
    end else begin
      crc_good      = crc_lo_good && (b.rx == crc_run[15:8]);
      v.frame_ok    = count_good && crc_good;
      v.length_ok   = count_good;
      v.crc_ok      = crc_good;
      v.status_byte = status_hold;
      verdict_q.push_back(v);
      frame_open = 1'b0;
      byte_pos   = 8'h00;
      return;
    end
    byte_pos = byte_pos + 8'd1;
  endtask

  task automatic push_byte(input logic [7:0] rx, input logic start, input logic [7:0] len);
    rx_item_t b;
    b.rx    = rx;
    b.start = start;
    b.len   = len;
    rx_queue.push_back(b);
    pushed++;
  endtask

  // Build a frame of len bytes; optionally spoil the count or the checksum,
  // or cut it short after cut bytes
  task automatic queue_frame(input int len, input bit bad_count, input bit bad_crc,
                             input int cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          n;
    body.push_back(bad_count ? 8'(len + $urandom_range(1, 255)) : 8'(len));
    for (int i = 1; i < len - 2; i++) body.push_back(8'($urandom));
    crc = 16'h0000;
    foreach (body[i]) crc = crc16_step(crc, body[i]);
    if (bad_crc) begin
      if ($urandom_range(1) == 1) crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
      else crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    n = (cut > 0 && cut < len) ? cut : len;
    for (int i = 0; i < n; i++) begin
      push_byte(body[i], i == 0, (i == 0) ? 8'(len) : 8'($urandom));
    end
  endtask

  // Single start byte with an expected length below the minimum
  task automatic queue_short();
    logic [7:0] len;
    len = 8'($urandom_range(0, 2));
    push_byte(($urandom_range(1) == 1) ? len : 8'($urandom), 1'b1, len);
  endtask

  // Mostly complete frames with random content, the rest broken or noise
  task automatic queue_random(input int n);
    int goal;
    int r;
    int len;
    goal = pushed + n;
    while (pushed < goal) begin
      r   = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
      if (r < 60) queue_frame(len, 1'b0, 1'b0, 0);
      else if (r < 70) queue_frame(len, 1'b1, 1'b0, 0);
      else if (r < 80) queue_frame(len, 1'b0, 1'b1, 0);
      else if (r < 87) queue_frame(len, 1'($urandom_range(1)), 1'b0, $urandom_range(1, len - 1));
      else if (r < 94) queue_short();
      else begin
        // stray byte between frames, not counted
        push_byte(8'($urandom), 1'b0, 8'($urandom));
        pushed--;
      end
    end
  endtask

  // Hold the sender until every byte is taken and every verdict has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_queue.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  // Compare one verdict transaction with the oldest expectation
  task automatic check_verdict();
    res_t got;
    res_t want;
    got.frame_ok    = out_frame_ok;
    got.length_ok   = out_length_ok;
    got.crc_ok      = out_crc_ok;
    got.status_byte = out_status_byte;
    verdicts_seen++;
    if (got.frame_ok === 1'b1) good_frames++;
    if (verdict_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: verdict with nothing pending: ok=%b len_ok=%b crc_ok=%b status=%02h",
                 $realtime, got.frame_ok, got.length_ok, got.crc_ok, got.status_byte);
      return;
    end
    want = verdict_q.pop_front();
    if (got.frame_ok !== want.frame_ok || got.length_ok !== want.length_ok ||
        got.crc_ok !== want.crc_ok || got.status_byte !== want.status_byte) begin
      fail_count++;
      // flags print as ok, len_ok, crc_ok, then the status byte
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: verdict mismatch: expected %b%b%b/%02h, got %b%b%b/%02h",
                 $realtime, want.frame_ok, want.length_ok, want.crc_ok, want.status_byte,
                 got.frame_ok, got.length_ok, got.crc_ok, got.status_byte);
    end
  endtask

  // Drive byte transactions; a stalled transaction stays put
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_byte(cur_byte);
        bytes_taken++;
      end
      if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_byte        = rx_queue.pop_front();
        in_valid        <= 1'b1;
        in_rx_byte      <= cur_byte.rx;
        in_frame_start  <= cur_byte.start;
        in_expected_len <= cur_byte.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Take verdict transactions and drive the receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_verdict();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short expected lengths, stray byte, minimal frame, bad checksum,
    // restart mid-frame, wrong count byte
    push_byte(8'h00, 1'b1, 8'h00);
    push_byte(8'h07, 1'b1, 8'h01);
    push_byte(8'h02, 1'b1, 8'h02);
    push_byte(8'hFF, 1'b0, 8'hFF);
    queue_frame(3, 1'b0, 1'b0, 0);
    queue_frame(4, 1'b0, 1'b0, 0);
    queue_frame(5, 1'b0, 1'b1, 0);
    queue_frame(6, 1'b0, 1'b0, 2);
    queue_frame(3, 1'b0, 1'b0, 0);
    push_byte(8'hFF, 1'b1, 8'hFF);
    queue_frame(4, 1'b1, 1'b0, 0);
    wait_drained();

    // Sender idles lightly, receiver heavily
    send_idle_pct = 24;
    recv_idle_pct = 64;
    queue_random(600);
    wait_drained();

    // Back-pressure: receiver holds off while short frames keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 40; k++) begin
      queue_short();
      queue_frame(3, 1'b0, 1'b0, 0);
    end
    hold_req = 1'b1;
    wait_drained();

    // Sender idles heavily, receiver lightly
    send_idle_pct = 64;
    recv_idle_pct = 24;
    queue_random(600);
    wait_drained();

    // Full rate, with one frame of the largest length
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_frame(255, 1'b0, 1'b0, 0);
    queue_random(260);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) fail_count += verdict_q.size();

    $display("Sent %0d bytes (%0d dropped outside a frame), checked %0d verdicts",
             bytes_taken, dropped_bytes, verdicts_seen);
    $display("Frames passing: %0d, failing: %0d, with one long receiver hold-off",
             good_frames, verdicts_seen - good_frames);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/crc16rfc_pkg.sv
hdl/crc16_response_frame_checker.sv
hdl/crc16rfc_checker.sv
bench/tb.sv
